>>> hdl/yle_pkg.sv
package yle_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_C       = 8'h43;

    localparam logic [3:0] CHROMA_LEN = 4'd7;
    localparam logic [3:0] CHROMA_BAD = 4'd8;

    typedef enum logic [2:0] {
        PH_MAGIC    = 3'd0,
        PH_SEP      = 3'd1,
        PH_TAG      = 3'd2,
        PH_IDLE     = 3'd3,
        PH_FRAMEHDR = 3'd4,
        PH_LUMA     = 3'd5,
        PH_CHROMA   = 3'd6,
        PH_REJECT   = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_W    = 2'd1,
        TAG_H    = 2'd2,
        TAG_C    = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_TRUNC  = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  luma;
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
    } result_t;

    // Results caused by one byte: first always valid, second when two is set
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } pair_t;

    function automatic logic [7:0] chroma_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h34;  // 4
            3'd1:    c = 8'h32;  // 2
            3'd2:    c = 8'h30;  // 0
            3'd3:    c = 8'h6A;  // j
            3'd4:    c = 8'h70;  // p
            3'd5:    c = 8'h65;  // e
            3'd6:    c = 8'h67;  // g
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic result_t status_result(input kind_t k);
        result_t r;
        r.kind      = k;
        r.luma      = 8'd0;
        r.pixel_row = 12'd0;
        r.pixel_col = 12'd0;
        return r;
    endfunction

endpackage

>>> hdl/yle_front.sv
module yle_front #(
    parameter int MAX_DIM = yle_pkg::MAX_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  yle_pkg::byte_item_t byte_item,
    input  logic               full,
    output logic               push,
    output yle_pkg::pair_t     push_entry
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int HALF_W = DIM_W - 1;
    localparam int PROD_W = 2 * HALF_W;
    localparam int CRW = PROD_W + 1;
    localparam int ACC_W = DIM_W + 4;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    yle_pkg::phase_t phase_reg, phase_next;
    yle_pkg::tag_t   tag_reg, tag_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic [3:0]       cpos_reg, cpos_next;
    logic             cok_reg, cok_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [CRW-1:0]   crem_reg, crem_next;
    logic [PROD_W-1:0] prod_reg;

    logic             accept;
    logic [1:0]       n_res;
    yle_pkg::result_t res [2];
    logic [7:0]       b;
    logic             is_digit;
    logic             do_end_tok;
    logic             do_hdr_done;
    logic             do_start;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] base;
    logic [DIM_W+11:0] row_ext;
    logic [DIM_W+11:0] col_ext;

    assign accept = byte_valid && !full;
    assign b = byte_item.data_byte;
    assign is_digit = (b >= yle_pkg::CH_ZERO) && (b <= yle_pkg::CH_NINE);
    assign row_ext = {12'd0, row_reg};
    assign col_ext = {12'd0, col_reg};

    // Size digit accumulate, shared by W and H
    always_comb
    begin
        base = (tag_reg == yle_pkg::TAG_H) ? ACC_W'(height_reg) : ACC_W'(width_reg);
        acc = (base << 3) + (base << 1) + ACC_W'(b - yle_pkg::CH_ZERO);
        if (acc > ACC_W'(MAX_DIM))
        begin
            acc = ACC_W'(MAX_DIM);
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        width_next  = width_reg;
        height_next = height_reg;
        cpos_next   = cpos_reg;
        cok_next    = cok_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        crem_next   = crem_reg;
        n_res       = 2'd0;
        res[0]      = yle_pkg::status_result(yle_pkg::KIND_DONE);
        res[1]      = yle_pkg::status_result(yle_pkg::KIND_DONE);
        do_end_tok  = 1'b0;
        do_hdr_done = 1'b0;
        do_start    = 1'b0;

        case (phase_reg)
            yle_pkg::PH_MAGIC:
            begin
                if (b == yle_pkg::CH_SPACE)
                    phase_next = yle_pkg::PH_SEP;
                else if (b == yle_pkg::CH_NEWLINE)
                    do_hdr_done = 1'b1;
            end
            yle_pkg::PH_SEP:
            begin
                if (b == yle_pkg::CH_NEWLINE)
                begin
                    do_hdr_done = 1'b1;
                end
                else if (b != yle_pkg::CH_SPACE)
                begin
                    phase_next = yle_pkg::PH_TAG;
                    if (b == yle_pkg::CH_W)
                    begin
                        tag_next = yle_pkg::TAG_W;
                        width_next = '0;
                    end
                    else if (b == yle_pkg::CH_H)
                    begin
                        tag_next = yle_pkg::TAG_H;
                        height_next = '0;
                    end
                    else if (b == yle_pkg::CH_C)
                    begin
                        tag_next = yle_pkg::TAG_C;
                        cpos_next = 4'd0;
                    end
                    else
                    begin
                        tag_next = yle_pkg::TAG_NONE;
                    end
                end
            end
            yle_pkg::PH_TAG:
            begin
                if (b == yle_pkg::CH_SPACE)
                begin
                    do_end_tok = 1'b1;
                    phase_next = yle_pkg::PH_SEP;
                end
                else if (b == yle_pkg::CH_NEWLINE)
                begin
                    do_end_tok = 1'b1;
                    do_hdr_done = 1'b1;
                end
                else
                begin
                    case (tag_reg)
                        yle_pkg::TAG_W:
                        begin
                            if (is_digit)
                                width_next = acc[DIM_W-1:0];
                            else
                                tag_next = yle_pkg::TAG_NONE;
                        end
                        yle_pkg::TAG_H:
                        begin
                            if (is_digit)
                                height_next = acc[DIM_W-1:0];
                            else
                                tag_next = yle_pkg::TAG_NONE;
                        end
                        yle_pkg::TAG_C:
                        begin
                            if (cpos_reg < yle_pkg::CHROMA_LEN &&
                                yle_pkg::chroma_char(cpos_reg[2:0]) == b)
                                cpos_next = cpos_reg + 4'd1;
                            else
                                cpos_next = yle_pkg::CHROMA_BAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            yle_pkg::PH_IDLE:
            begin
                if (b == yle_pkg::CH_NEWLINE)
                    do_start = 1'b1;
                else
                    phase_next = yle_pkg::PH_FRAMEHDR;
            end
            yle_pkg::PH_FRAMEHDR:
            begin
                if (b == yle_pkg::CH_NEWLINE)
                    do_start = 1'b1;
            end
            yle_pkg::PH_LUMA:
            begin
                res[0].kind      = yle_pkg::KIND_PIXEL;
                res[0].luma      = b;
                res[0].pixel_row = row_ext[11:0];
                res[0].pixel_col = col_ext[11:0];
                n_res = 2'd1;
                if (col_reg + DIM_W'(1) == width_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + DIM_W'(1);
                    if (row_next == height_reg)
                    begin
                        if (crem_reg == '0)
                        begin
                            res[1] = yle_pkg::status_result(yle_pkg::KIND_DONE);
                            n_res = 2'd2;
                            phase_next = yle_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = yle_pkg::PH_CHROMA;
                        end
                    end
                end
                else
                begin
                    col_next = col_reg + DIM_W'(1);
                end
            end
            yle_pkg::PH_CHROMA:
            begin
                if (crem_reg != '0)
                    crem_next = crem_reg - CRW'(1);
                if (crem_next == '0)
                begin
                    res[0] = yle_pkg::status_result(yle_pkg::KIND_DONE);
                    n_res = 2'd1;
                    phase_next = yle_pkg::PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        if (do_end_tok)
        begin
            if (tag_reg == yle_pkg::TAG_C)
                cok_next = (cpos_next == 4'd0) || (cpos_next == yle_pkg::CHROMA_LEN);
            tag_next = yle_pkg::TAG_NONE;
        end

        if (do_hdr_done)
        begin
            if (cok_next)
            begin
                phase_next = yle_pkg::PH_IDLE;
            end
            else
            begin
                res[0] = yle_pkg::status_result(yle_pkg::KIND_REJECT);
                n_res = 2'd1;
                phase_next = yle_pkg::PH_REJECT;
            end
        end

        if (do_start)
        begin
            row_next = '0;
            col_next = '0;
            crem_next = {prod_reg, 1'b0};
            if (width_reg == '0 || height_reg == '0)
            begin
                res[0] = yle_pkg::status_result(yle_pkg::KIND_DONE);
                n_res = 2'd1;
                phase_next = yle_pkg::PH_IDLE;
            end
            else
            begin
                phase_next = yle_pkg::PH_LUMA;
            end
        end

        // Close out the stream, then return to the reset state
        if (byte_item.end_of_stream)
        begin
            if (phase_next == yle_pkg::PH_MAGIC || phase_next == yle_pkg::PH_SEP ||
                phase_next == yle_pkg::PH_TAG)
            begin
                if (phase_next == yle_pkg::PH_TAG && tag_next == yle_pkg::TAG_C)
                    cok_next = (cpos_next == 4'd0) || (cpos_next == yle_pkg::CHROMA_LEN);
                if (!cok_next)
                begin
                    res[n_res[0]] = yle_pkg::status_result(yle_pkg::KIND_REJECT);
                    n_res = n_res + 2'd1;
                end
            end
            else if (phase_next == yle_pkg::PH_FRAMEHDR || phase_next == yle_pkg::PH_LUMA ||
                     phase_next == yle_pkg::PH_CHROMA)
            begin
                res[n_res[0]] = yle_pkg::status_result(yle_pkg::KIND_TRUNC);
                n_res = n_res + 2'd1;
            end
            phase_next  = yle_pkg::PH_MAGIC;
            tag_next    = yle_pkg::TAG_NONE;
            width_next  = '0;
            height_next = '0;
            cpos_next   = 4'd0;
            cok_next    = 1'b1;
            row_next    = '0;
            col_next    = '0;
            crem_next   = '0;
        end
    end

    assign push = accept && (n_res != 2'd0);
    assign push_entry.two    = (n_res == 2'd2);
    assign push_entry.first  = res[0];
    assign push_entry.second = res[1];

    // Sizes settle at least one byte before the FRAME newline uses the product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(width_reg[DIM_W-1:1]) * PROD_W'(height_reg[DIM_W-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= yle_pkg::PH_MAGIC;
            tag_reg    <= yle_pkg::TAG_NONE;
            width_reg  <= '0;
            height_reg <= '0;
            cpos_reg   <= 4'd0;
            cok_reg    <= 1'b1;
            row_reg    <= '0;
            col_reg    <= '0;
            crem_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            cpos_reg   <= cpos_next;
            cok_reg    <= cok_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            crem_reg   <= crem_next;
        end
    end

    // DIM_MAX bounds the size registers
    always_comb
    begin
        if (width_reg > DIM_MAX || height_reg > DIM_MAX)
            $error("frame size above limit");
    end

endmodule

>>> hdl/yle_queue.sv
module yle_queue #(
    parameter int DEPTH = yle_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  yle_pkg::pair_t push_entry,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output yle_pkg::pair_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    yle_pkg::pair_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not advance on push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

>>> hdl/yle_back.sv
module yle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  yle_pkg::pair_t    head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output yle_pkg::result_t  res_item
);

    logic             valid_reg, valid_next;
    logic             sub_reg, sub_next;
    yle_pkg::result_t data_reg, data_next;
    logic             load;

    assign load = head_valid && (!valid_reg || !res_stall);

    always_comb
    begin
        valid_next = valid_reg;
        sub_next = sub_reg;
        data_next = data_reg;
        pop = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            data_next = sub_reg ? head.second : head.first;
            // Drop the entry once its last result is out
            pop = !head.two || sub_reg;
            sub_next = !pop;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg <= sub_next;
        end
    end

    assign res_valid = valid_reg;
    assign res_item = data_reg;

    a_sub_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (sub_reg && head_valid) |-> head.two)
        else $error("second result pending on single entry");

    a_sub_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sub_reg) |-> valid_reg)
        else $error("second result pending without first shown");

    a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> load)
        else $error("entry dropped without loading a result");

endmodule

>>> hdl/y4m_luma_extractor_unit.sv
// Byte-serial Y4M parser that passes on the luma plane of 420jpeg video. It takes one stream
// byte per clock on the byte channel while byte_stall is low and returns luma samples with
// row and column, a frame complete or truncated mark, or a format reject mark on the result
// channel, at most one result per clock. A byte is classified and its results formed in the
// cycle it is accepted. A four-entry queue of per-byte result groups sits between parser and
// output register; a byte can yield two results (a last luma sample and its frame mark, or a
// result and an end-of-stream mark), shown in turn, which the queue absorbs while header, FRAME
// and chroma bytes, mostly yielding none, keep the parser at one byte per cycle. byte_stall
// rises only when that queue is full. Sizes saturate at MAX_DIM.
module y4m_luma_extractor_unit #(
    parameter int MAX_DIM = yle_pkg::MAX_DIM_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  yle_pkg::byte_item_t byte_item,
    output logic                res_valid,
    input  logic                res_stall,
    output yle_pkg::result_t    res_item
);

    logic           full;
    logic           push;
    logic           pop;
    logic           head_valid;
    yle_pkg::pair_t push_entry;
    yle_pkg::pair_t head;

    assign byte_stall = full;

    yle_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_item (byte_item),
        .full      (full),
        .push      (push),
        .push_entry(push_entry)
    );

    yle_queue #(
        .DEPTH(yle_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .full      (full),
        .head_valid(head_valid),
        .head      (head)
    );

    yle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
